### hdl/btpg_pkg.sv
`default_nettype none
package btpg_pkg;

	localparam int unsigned GlyphBits = 30;
	localparam int unsigned GlyphCount = 36;

	localparam logic [2:0] NARROW_W = 3'd3;
	localparam logic [2:0] WIDE_W = 3'd5;
	localparam logic [2:0] LAST_ROW = 3'd5;
	localparam logic [15:0] SPACE_ADVANCE = 16'd3;
	localparam logic [5:0] DIGIT_BASE = 6'd26;
	localparam logic [5:0] IDX_M = 6'd12;
	localparam logic [5:0] IDX_W = 6'd22;

	localparam logic [7:0] CH_SPACE_CODE = 8'h20;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_Z = 8'h5A;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;

	typedef enum logic [1:0] {
		CK_GLYPH,
		CK_SPACE,
		CK_OTHER
	} char_kind_t;

	typedef struct packed {
		char_kind_t kind;
		logic [5:0] idx;
	} char_dec_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} scan_state_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [23:0] color;
		logic last;
	} pix_t;

	function automatic char_dec_t decode_char(input logic [7:0] ch);
		char_dec_t d;
		d.kind = CK_OTHER;
		d.idx = 6'd0;
		if (ch == CH_SPACE_CODE) begin
			d.kind = CK_SPACE;
		end else if (ch >= CH_A && ch <= CH_Z) begin
			d.kind = CK_GLYPH;
			d.idx = 6'(ch - CH_A);
		end else if (ch >= CH_0 && ch <= CH_9) begin
			d.kind = CK_GLYPH;
			d.idx = DIGIT_BASE + 6'(ch - CH_0);
		end
		return d;
	endfunction

	// bit k * width + j holds glyph row k, column j
	function automatic logic [GlyphBits-1:0] glyph_word(input logic [5:0] idx);
		logic [GlyphBits-1:0] w;
		unique case (idx)
			6'd0: w = 30'h1DF6D;
			6'd1: w = 30'h35F6F;
			6'd2: w = 30'h1C927;
			6'd3: w = 30'h35B6E;
			6'd4: w = 30'h3CD27;
			6'd5: w = 30'h1CD24;
			6'd6: w = 30'h1C96F;
			6'd7: w = 30'h2DF6D;
			6'd8: w = 30'h3A497;
			6'd9: w = 30'h3924E;
			6'd10: w = 30'h2DD6D;
			6'd11: w = 30'h24927;
			6'd12: w = 30'h3D5AD6B1;
			6'd13: w = 30'h35B6D;
			6'd14: w = 30'h1DB6E;
			6'd15: w = 30'h3DD24;
			6'd16: w = 30'h1DB71;
			6'd17: w = 30'h3DD6D;
			6'd18: w = 30'h1CE4E;
			6'd19: w = 30'h3A492;
			6'd20: w = 30'h2DB6F;
			6'd21: w = 30'h2DB6A;
			6'd22: w = 30'h235AD6AA;
			6'd23: w = 30'h2D4AD;
			6'd24: w = 30'h2DA92;
			6'd25: w = 30'h394A7;
			6'd26: w = 30'h1DB6E;
			6'd27: w = 30'h16497;
			6'd28: w = 30'h312A7;
			6'd29: w = 30'h31C4E;
			6'd30: w = 30'h2D649;
			6'd31: w = 30'h3CC4E;
			6'd32: w = 30'h1CD6B;
			6'd33: w = 30'h39292;
			6'd34: w = 30'h1D56E;
			6'd35: w = 30'h35ACE;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

### hdl/btpg_scan.sv
`default_nettype none
module btpg_scan (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic first_of_string,
	input wire logic [7:0] char_code,
	input wire logic [15:0] start_x,
	input wire logic [15:0] start_y,
	input wire logic [23:0] pixel_color_in,
	input wire logic pix_ready,
	output logic pix_valid,
	output btpg_pkg::pix_t pix
);

	btpg_pkg::scan_state_t state_q, state_nxt;
	logic [15:0] cursor_q, cursor_nxt;
	logic [15:0] origin_q, origin_nxt;
	logic [btpg_pkg::GlyphBits-1:0] word_q, word_nxt;
	logic [btpg_pkg::GlyphBits-1:0] rem_q, rem_nxt;
	logic wide_q, wide_nxt;
	logic [2:0] col_q, col_nxt;
	logic [2:0] row_q, row_nxt;
	logic [4:0] bit_q, bit_nxt;
	logic [23:0] color_q, color_nxt;

	btpg_pkg::char_dec_t dec;
	logic [15:0] cursor_base;
	logic [2:0] width;
	logic [btpg_pkg::GlyphBits-1:0] bit_mask;
	logic [btpg_pkg::GlyphBits-1:0] rem_left;
	logic cur_set;
	logic step;

	assign dec = btpg_pkg::decode_char(char_code);
	assign cursor_base = first_of_string ? start_x : cursor_q;
	assign width = wide_q ? btpg_pkg::WIDE_W : btpg_pkg::NARROW_W;
	assign bit_mask = btpg_pkg::GlyphBits'(1) << bit_q;
	assign rem_left = rem_q & ~bit_mask;
	assign cur_set = word_q[bit_q];

	assign in_stall = (state_q != btpg_pkg::ST_IDLE);

	// a clear bit always moves on; a set bit waits for room in the output word
	assign step = (state_q == btpg_pkg::ST_SCAN) && (!cur_set || pix_ready);

	assign pix_valid = (state_q == btpg_pkg::ST_SCAN) && cur_set;
	assign pix.x = cursor_q + {13'd0, width - col_q};
	assign pix.y = origin_q + {13'd0, btpg_pkg::LAST_ROW - row_q};
	assign pix.color = color_q;
	assign pix.last = (rem_left == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btpg_pkg::ST_IDLE;
			cursor_q <= '0;
			origin_q <= '0;
		end else begin
			state_q <= state_nxt;
			cursor_q <= cursor_nxt;
			origin_q <= origin_nxt;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_nxt;
		rem_q <= rem_nxt;
		wide_q <= wide_nxt;
		col_q <= col_nxt;
		row_q <= row_nxt;
		bit_q <= bit_nxt;
		color_q <= color_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		cursor_nxt = cursor_q;
		origin_nxt = origin_q;
		word_nxt = word_q;
		rem_nxt = rem_q;
		wide_nxt = wide_q;
		col_nxt = col_q;
		row_nxt = row_q;
		bit_nxt = bit_q;
		color_nxt = color_q;
		unique case (state_q)
			btpg_pkg::ST_IDLE: begin
				if (in_valid) begin
					cursor_nxt = cursor_base;
					if (first_of_string) begin
						origin_nxt = start_y;
					end
					case (dec.kind)
						btpg_pkg::CK_SPACE: begin
							cursor_nxt = cursor_base + btpg_pkg::SPACE_ADVANCE;
						end
						btpg_pkg::CK_GLYPH: begin
							word_nxt = btpg_pkg::glyph_word(dec.idx);
							rem_nxt = btpg_pkg::glyph_word(dec.idx);
							wide_nxt = (dec.idx == btpg_pkg::IDX_M) ||
								(dec.idx == btpg_pkg::IDX_W);
							col_nxt = '0;
							row_nxt = '0;
							bit_nxt = '0;
							color_nxt = pixel_color_in;
							state_nxt = btpg_pkg::ST_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			btpg_pkg::ST_SCAN: begin
				if (step) begin
					rem_nxt = rem_left;
					if (row_q == btpg_pkg::LAST_ROW) begin
						row_nxt = '0;
						col_nxt = col_q + 3'd1;
						bit_nxt = {2'd0, col_q + 3'd1};
						if (col_q == width - 3'd1) begin
							// glyph done: advance the cursor past it and a gap column
							cursor_nxt = cursor_q + {13'd0, width} + 16'd1;
							state_nxt = btpg_pkg::ST_IDLE;
						end
					end else begin
						row_nxt = row_q + 3'd1;
						bit_nxt = bit_q + {2'd0, width};
					end
				end
			end
			default: begin
				state_nxt = btpg_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

### hdl/btpg_pix_out.sv
`default_nettype none
module btpg_pix_out (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pix_valid,
	input wire btpg_pkg::pix_t pix,
	output logic pix_ready,
	output logic out_valid,
	input wire logic out_stall,
	output logic [15:0] pixel_x,
	output logic [15:0] pixel_y,
	output logic [23:0] pixel_color,
	output logic last_pixel
);

	logic valid_q;
	btpg_pkg::pix_t pix_q;

	// take a new word when empty or when the held one leaves this cycle
	assign pix_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pix_ready) begin
			valid_q <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_ready && pix_valid) begin
			pix_q <= pix;
		end
	end

	assign out_valid = valid_q;
	assign pixel_x = pix_q.x;
	assign pixel_y = pix_q.y;
	assign pixel_color = pix_q.color;
	assign last_pixel = pix_q.last;

endmodule
`default_nettype wire

### hdl/bitmap_text_pixel_generator_top.sv
// Letters and digits: one glyph bit per cycle, 18 bits (3 columns) or 30 bits (5 columns),
// so the input is stalled after the accept until the glyph is scanned; output stall adds to that.
// A set bit lands in the output register at the end of its scan cycle.
// Space and unsupported codes finish in the accept cycle; the next word may follow at once.
// While a pixel waits in the output register, clear bits still advance; a set bit holds.
// arst_n clears the cursor, the origin row, the sequencer and the output valid.
`default_nettype none
module bitmap_text_pixel_generator_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic first_of_string,
	input wire logic [7:0] char_code,
	input wire logic [15:0] start_x,
	input wire logic [15:0] start_y,
	input wire logic [23:0] pixel_color_in,
	output logic out_valid,
	input wire logic out_stall,
	output logic [15:0] pixel_x,
	output logic [15:0] pixel_y,
	output logic [23:0] pixel_color,
	output logic last_pixel
);

	logic pix_ready;
	logic pix_valid;
	btpg_pkg::pix_t pix;

	btpg_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.first_of_string(first_of_string),
		.char_code(char_code),
		.start_x(start_x),
		.start_y(start_y),
		.pixel_color_in(pixel_color_in),
		.pix_ready(pix_ready),
		.pix_valid(pix_valid),
		.pix(pix)
	);

	btpg_pix_out u_pix_out (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix(pix),
		.pix_ready(pix_ready),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_color(pixel_color),
		.last_pixel(last_pixel)
	);

endmodule
`default_nettype wire

### hdl/btpg_checker.sv
`default_nettype none
module btpg_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic [7:0] char_code,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [15:0] pixel_x,
	input wire logic [15:0] pixel_y,
	input wire logic last_pixel
);

	logic acc_glyph;
	logic acc_short;

	assign acc_glyph = in_valid && !in_stall &&
		((char_code >= btpg_pkg::CH_A && char_code <= btpg_pkg::CH_Z) ||
		(char_code >= btpg_pkg::CH_0 && char_code <= btpg_pkg::CH_9));
	assign acc_short = in_valid && !in_stall && !acc_glyph;

	// hold a stalled pixel word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y))
		else $error("stalled pixel word changed");

	// a glyph occupies the sequencer after its accept
	a_glyph_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_glyph |=> in_stall)
		else $error("input not stalled after glyph accept");

	// space and unsupported codes finish at once
	a_short_free: assert property (@(posedge clk) disable iff (!arst_n)
		acc_short |=> !in_stall)
		else $error("input stalled after non-glyph word");

	// a pixel that is not last means the glyph scan is still running
	a_not_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_pixel |-> in_stall)
		else $error("non-last pixel while sequencer idle");

endmodule

bind bitmap_text_pixel_generator_top btpg_checker u_btpg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.char_code(char_code),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.pixel_x(pixel_x),
	.pixel_y(pixel_y),
	.last_pixel(last_pixel)
);
`default_nettype wire

### verif/glyph_pixel_checker.sv
`timescale 1ns / 1ps
module glyph_pixel_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic first_of_string,
	input logic [7:0] char_code,
	input logic [15:0] start_x,
	input logic [15:0] start_y,
	input logic [23:0] pixel_color_in,
	input logic out_valid,
	input logic out_stall,
	input logic [15:0] pixel_x,
	input logic [15:0] pixel_y,
	input logic [23:0] pixel_color,
	input logic last_pixel,
	output int mismatch_count,
	output int pixels_pending
);

	// entry 0 in the low bits: A..Z then 0..9
	localparam logic [35:0][29:0] FONT_ROM = {
		30'h35ACE, 30'h1D56E, 30'h39292, 30'h1CD6B, 30'h3CC4E, 30'h2D649,
		30'h31C4E, 30'h312A7, 30'h16497, 30'h1DB6E, 30'h394A7, 30'h2DA92,
		30'h2D4AD, 30'h235AD6AA, 30'h2DB6A, 30'h2DB6F, 30'h3A492, 30'h1CE4E,
		30'h3DD6D, 30'h1DB71, 30'h3DD24, 30'h1DB6E, 30'h35B6D, 30'h3D5AD6B1,
		30'h24927, 30'h2DD6D, 30'h3924E, 30'h3A497, 30'h2DF6D, 30'h1C96F,
		30'h1CD24, 30'h3CD27, 30'h35B6E, 30'h1C927, 30'h35F6F, 30'h1DF6D
	};

	btpg_pkg::pix_t expected_pixels[$];
	logic [15:0] cursor_x;
	logic [15:0] string_row;

	initial begin
		mismatch_count = 0;
		pixels_pending = 0;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("ERROR %0t ns: %s", $time, msg);
	endtask

	task automatic draw_char_pixels(input logic first, input logic [7:0] ch,
			input logic [15:0] sx, input logic [15:0] sy, input logic [23:0] color);
		logic [5:0] idx;
		logic [29:0] bits;
		int unsigned w;
		btpg_pkg::pix_t p;
		btpg_pkg::pix_t glyph_pixels[$];
		if (first) begin
			cursor_x = sx;
			string_row = sy;
		end
		if (ch == btpg_pkg::CH_SPACE_CODE) begin
			cursor_x = cursor_x + btpg_pkg::SPACE_ADVANCE;
			return;
		end
		if (ch >= btpg_pkg::CH_A && ch <= btpg_pkg::CH_Z)
			idx = 6'(ch - btpg_pkg::CH_A);
		else if (ch >= btpg_pkg::CH_0 && ch <= btpg_pkg::CH_9)
			idx = btpg_pkg::DIGIT_BASE + 6'(ch - btpg_pkg::CH_0);
		else
			return;
		w = (idx == btpg_pkg::IDX_M || idx == btpg_pkg::IDX_W) ?
			btpg_pkg::WIDE_W : btpg_pkg::NARROW_W;
		bits = FONT_ROM[idx];
		// column-major scan, rows bottom-up in the word
		for (int unsigned j = 0; j < w; j++) begin
			for (int unsigned k = 0; k < 6; k++) begin
				if (bits[k * w + j]) begin
					p.x = cursor_x + 16'(w) - 16'(j);
					p.y = string_row + 16'(btpg_pkg::LAST_ROW) - 16'(k);
					p.color = color;
					p.last = 1'b0;
					glyph_pixels.push_back(p);
				end
			end
		end
		if (glyph_pixels.size() > 0)
			glyph_pixels[glyph_pixels.size() - 1].last = 1'b1;
		foreach (glyph_pixels[i])
			expected_pixels.push_back(glyph_pixels[i]);
		cursor_x = cursor_x + 16'(w) + 16'd1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		btpg_pkg::pix_t exp_pix;
		if (!arst_n) begin
			cursor_x = '0;
			string_row = '0;
			expected_pixels.delete();
			pixels_pending = 0;
		end else begin
			if (in_valid && !in_stall)
				draw_char_pixels(first_of_string, char_code, start_x, start_y, pixel_color_in);
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("unexpected pixel x=%h y=%h", pixel_x, pixel_y));
				end else begin
					exp_pix = expected_pixels.pop_front();
					if (pixel_x !== exp_pix.x)
						report_mismatch($sformatf("pixel_x %h, want %h", pixel_x, exp_pix.x));
					if (pixel_y !== exp_pix.y)
						report_mismatch($sformatf("pixel_y %h, want %h", pixel_y, exp_pix.y));
					if (pixel_color !== exp_pix.color)
						report_mismatch($sformatf("pixel_color %h, want %h",
							pixel_color, exp_pix.color));
					if (last_pixel !== exp_pix.last)
						report_mismatch($sformatf("last_pixel %b, want %b at x=%h y=%h",
							last_pixel, exp_pix.last, exp_pix.x, exp_pix.y));
				end
			end
			pixels_pending = expected_pixels.size();
		end
	end

endmodule

### verif/bitmap_text_pixel_generator_top_tb.sv
`timescale 1ns / 1ps
module bitmap_text_pixel_generator_top_tb;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic first_of_string;
	logic [7:0] char_code;
	logic [15:0] start_x;
	logic [15:0] start_y;
	logic [23:0] pixel_color_in;
	logic out_valid;
	logic out_stall;
	logic [15:0] pixel_x;
	logic [15:0] pixel_y;
	logic [23:0] pixel_color;
	logic last_pixel;

	int fail_count;
	int pixels_pending;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int chars_left;

	bitmap_text_pixel_generator_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.first_of_string(first_of_string),
		.char_code(char_code),
		.start_x(start_x),
		.start_y(start_y),
		.pixel_color_in(pixel_color_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_color(pixel_color),
		.last_pixel(last_pixel)
	);

	glyph_pixel_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.first_of_string(first_of_string),
		.char_code(char_code),
		.start_x(start_x),
		.start_y(start_y),
		.pixel_color_in(pixel_color_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_color(pixel_color),
		.last_pixel(last_pixel),
		.mismatch_count(fail_count),
		.pixels_pending(pixels_pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#6_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// pixel sink: a pending long hold overrides the random stall
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// call and return at a rising edge; returns at the edge that takes the word
	task automatic send_char(input logic first, input logic [7:0] ch,
			input logic [15:0] sx, input logic [15:0] sy, input logic [23:0] color);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		first_of_string <= first;
		char_code <= ch;
		start_x <= sx;
		start_y <= sy;
		pixel_color_in <= color;
		forever begin
			@(negedge clk);
			if (!in_stall)
				break;
		end
		@(posedge clk);
	endtask

	task automatic wait_pixels_drained();
		in_valid <= 1'b0;
		forever begin
			@(negedge clk);
			if (pixels_pending == 0)
				break;
		end
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_coord();
		// lean on the top of the range to hit wraparound
		if ($urandom_range(3) == 0)
			return {12'hFFF, 4'($urandom)};
		return 16'($urandom);
	endfunction

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return btpg_pkg::CH_A + 8'($urandom_range(25));
		if (r < 70)
			return btpg_pkg::CH_0 + 8'($urandom_range(9));
		if (r < 82)
			return btpg_pkg::CH_SPACE_CODE;
		return 8'($urandom_range(255));
	endfunction

	task automatic send_random_char();
		logic first;
		first = (chars_left == 0);
		if (first)
			chars_left = $urandom_range(12, 1);
		chars_left--;
		send_char(first, pick_char(), pick_coord(), pick_coord(), 24'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		first_of_string = 1'b0;
		char_code = '0;
		start_x = '0;
		start_y = '0;
		pixel_color_in = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		chars_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// narrow and wide glyphs, range ends of letters and digits
		send_char(1'b1, "A", 16'h0000, 16'h0000, 24'h000000);
		send_char(1'b0, "M", 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
		send_char(1'b0, "W", 16'h1234, 16'h4321, 24'h123456);
		send_char(1'b0, "Z", 16'h0000, 16'h0000, 24'hFEDCBA);
		send_char(1'b0, "0", 16'h0000, 16'h0000, 24'h800001);
		send_char(1'b0, "9", 16'h0000, 16'h0000, 24'h7FFFFE);
		send_char(1'b0, " ", 16'h0000, 16'h0000, 24'h0F0F0F);
		// codes outside the accepted ranges, first those next to them: drop, no advance; then a K
		send_char(1'b0, 8'h40, 16'h0000, 16'h0000, 24'h111111);
		send_char(1'b0, 8'h5B, 16'h0000, 16'h0000, 24'h222222);
		send_char(1'b0, 8'h2F, 16'h0000, 16'h0000, 24'h333333);
		send_char(1'b0, 8'h3A, 16'h0000, 16'h0000, 24'h444444);
		send_char(1'b0, 8'h00, 16'h0000, 16'h0000, 24'h555555);
		send_char(1'b0, 8'hFF, 16'hFFFF, 16'hFFFF, 24'h666666);
		send_char(1'b0, "a", 16'h0000, 16'h0000, 24'h777777);
		send_char(1'b0, "K", 16'h0000, 16'h0000, 24'hFFFFFF);
		// origin load on an ignored code, then wrap in both coordinates
		send_char(1'b1, 8'h7F, 16'hFFFD, 16'hFFFE, 24'h000000);
		send_char(1'b0, "W", 16'h0000, 16'h0000, 24'hABCDEF);
		send_char(1'b1, " ", 16'hFFFF, 16'h0000, 24'h000000);
		send_char(1'b0, "M", 16'h0000, 16'h0000, 24'hC0FFEE);
		send_char(1'b1, "B", 16'hFFFC, 16'hFFFC, 24'hA5A5A5);
		send_char(1'b0, "Q", 16'h5555, 16'hAAAA, 24'h5A5A5A);
		send_char(1'b1, "8", 16'h8000, 16'h7FFF, 24'h5A5A5A);
		wait_pixels_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 48; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 48; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			if (ph == 0) begin
				// hold the sink off long enough to back up the input
				@(negedge clk);
				hold_left = 400;
				@(posedge clk);
			end
			for (int i = 0; i < 50; i++)
				send_random_char();
			if (ph == 1)
				wait_pixels_drained();
		end

		wait_pixels_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
